>>> rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the allocation bitmap run free/mark block.
// ----------------------------------------------------------------------------
package brf_pkg;

	// request / response field widths
	localparam int FIRST_INDEX_W = 20;
	localparam int RUN_LENGTH_W  = 15;
	localparam int FDS_W         = 20;

	// bit position of a run start: 0 .. 2**20
	localparam int START_W = FIRST_INDEX_W + 1;
	// start + length, and the signed sector offset
	localparam int END_W   = START_W + 1;

	// APB register file
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_DATA_SECTOR = 1'b0;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BAD_BIT = 2'd1,
		STATUS_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/brf_req_if.sv
// ----------------------------------------------------------------------------
// brf_req_if
// Request channel: map, mode, first index and run length.
// ----------------------------------------------------------------------------
interface brf_req_if;
	import brf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic                     map_select;
	logic [FIRST_INDEX_W-1:0] first_index;
	logic [RUN_LENGTH_W-1:0]  run_length;

	modport source(output valid, output mode, output map_select, output first_index,
		output run_length, input ready);
	modport sink(input valid, input mode, input map_select, input first_index,
		input run_length, output ready);

endinterface

>>> rtl/core/brf_rsp_if.sv
// ----------------------------------------------------------------------------
// brf_rsp_if
// Response channel: one status beat per request.
// ----------------------------------------------------------------------------
interface brf_rsp_if;
	import brf_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;

	modport source(output valid, output status, input ready);
	modport sink(input valid, input status, output ready);

endinterface

>>> rtl/core/bitmap_run_free_top.sv
// ----------------------------------------------------------------------------
// bitmap_run_free_top
// Sector and inode allocation bitmaps with run free / run mark requests.
// ----------------------------------------------------------------------------
// Refused or empty runs skip the divide and the walk and go straight to the
//   status beat, which an earlier beat not yet taken on rsp holds back.
// Throughput: one request at a time; a divide splits the start into word and
//   offset, then the read-modify-write loop walks one word per cycle.
// Reset: arst_n clears control and the register; then a clearing pass zeroes
//   both memories, max(sector words, inode words) deep, before requests are taken.
// ----------------------------------------------------------------------------
module bitmap_run_free_top #(
	parameter int SECTOR_MAP_BITS = 16384,
	parameter int INODE_MAP_BITS  = 4096,
	parameter int WORD_BITS       = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [brf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [brf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [brf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// data channels
	brf_req_if.sink                          req,
	brf_rsp_if.source                        rsp
);
	import brf_pkg::*;

	// map geometry
	localparam int SW    = (SECTOR_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int IW    = (INODE_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int SA_W  = (SW > 1) ? $clog2(SW) : 1;
	localparam int IA_W  = (IW > 1) ? $clog2(IW) : 1;
	localparam int MAXW  = (SW > IW) ? SW : IW;
	localparam int CLR_W = (MAXW > 1) ? $clog2(MAXW) : 1;
	localparam int OFF_W = $clog2(WORD_BITS);
	localparam int CNT_W = $clog2(WORD_BITS + 1);

	localparam logic [END_W-1:0]        SEC_LIM  = END_W'(SECTOR_MAP_BITS);
	localparam logic [END_W-1:0]        INO_LIM  = END_W'(INODE_MAP_BITS);
	localparam logic [CLR_W:0]          SW_V     = (CLR_W + 1)'(SW);
	localparam logic [CLR_W:0]          IW_V     = (CLR_W + 1)'(IW);
	localparam logic [CLR_W-1:0]        CLR_LAST = CLR_W'(MAXW - 1);
	localparam logic [RUN_LENGTH_W-1:0] WB_LEN   = RUN_LENGTH_W'(WORD_BITS);
	localparam logic [CNT_W-1:0]        WB_CNT   = CNT_W'(WORD_BITS);

	state_t state_q, state_d;

	// ---------------------------------------------------------------- config
	logic [FDS_W-1:0]     fds_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_FIRST_DATA_SECTOR)
		? {{(APB_DATA_W - FDS_W){1'b0}}, fds_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fds_q <= '0;
		end else if (cfg_wr && reg_idx == REG_FIRST_DATA_SECTOR) begin
			fds_q <= pwdata[FDS_W-1:0];
		end
	end

	// ------------------------------------------------------ request decode
	logic [END_W-1:0]   sec_start;
	logic [START_W-1:0] start_c;
	logic [END_W-1:0]   end_c;
	logic               range_bad;
	logic               len_zero;
	logic               accept;

	// sector bit = index - first_data_sector + 1; negative means refused
	assign sec_start = {2'b00, req.first_index} - {2'b00, fds_q} + END_W'(1);
	assign start_c   = req.map_select ? {1'b0, req.first_index} : sec_start[START_W-1:0];
	assign end_c     = {1'b0, start_c} + END_W'(req.run_length);
	assign range_bad = req.map_select ? (end_c > INO_LIM)
		: (sec_start[END_W-1] || end_c > SEC_LIM);
	assign len_zero  = req.run_length == '0;
	assign accept    = req.valid && req.ready;

	// -------------------------------------------------------------- divider
	logic                 div_go;
	logic                 div_done;
	logic [START_W-1:0]   div_quo;
	logic [OFF_W-1:0]     div_rem;

	brf_div #(
		.DIV_W     (START_W),
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (start_c),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ------------------------------------------------------- request state
	logic                    mode_q;
	logic                    map_q;
	logic [RUN_LENGTH_W-1:0] len_q;
	status_t                 stat_q;
	logic                    bad_q;

	// walk counters: current word, bit offset in it, bits still to cover
	logic [START_W-1:0]      w_q;
	logic [OFF_W-1:0]        off_q;
	logic [RUN_LENGTH_W-1:0] left_q;
	logic                    issue;
	logic [RUN_LENGTH_W-1:0] room;
	logic [RUN_LENGTH_W-1:0] take;
	logic [CNT_W-1:0]        n;
	logic [WORD_BITS-1:0]    ones;
	logic [WORD_BITS-1:0]    mask;

	assign issue = (state_q == ST_WALK) && (left_q != '0);
	assign room  = WB_LEN - RUN_LENGTH_W'(off_q);
	assign take  = (left_q < room) ? left_q : room;
	assign n     = take[CNT_W-1:0];
	assign ones  = (n == WB_CNT) ? '1
		: (({{(WORD_BITS - 1){1'b0}}, 1'b1} << n) - {{(WORD_BITS - 1){1'b0}}, 1'b1});
	assign mask  = ones << off_q;

	// stage 1: read data back, merge, write
	logic                 vld_s1;
	logic [START_W-1:0]   addr_s1;
	logic [WORD_BITS-1:0] mask_s1;

	// clearing pass
	logic [CLR_W-1:0]     clr_q;
	logic                 clr_done;
	logic                 clearing;

	assign clearing = state_q == ST_CLEAR;
	assign clr_done = clr_q == CLR_LAST;

	// ------------------------------------------------------------- memories
	logic [WORD_BITS-1:0] smem [SW];
	logic [WORD_BITS-1:0] imem [IW];
	logic [WORD_BITS-1:0] s_rdata_q;
	logic [WORD_BITS-1:0] i_rdata_q;
	logic                 s_re, i_re, s_we, i_we;
	logic [SA_W-1:0]      s_waddr;
	logic [IA_W-1:0]      i_waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] hit;
	logic                 word_bad;
	logic [WORD_BITS-1:0] new_word;

	assign rdata    = map_q ? i_rdata_q : s_rdata_q;
	assign hit      = rdata & mask_s1;
	assign word_bad = mode_q ? (hit != '0) : (hit != mask_s1);
	assign new_word = mode_q ? (rdata | mask_s1) : (rdata & ~mask_s1);

	assign s_re    = issue && !map_q;
	assign i_re    = issue && map_q;
	assign s_we    = clearing ? ({1'b0, clr_q} < SW_V) : (vld_s1 && !map_q);
	assign i_we    = clearing ? ({1'b0, clr_q} < IW_V) : (vld_s1 && map_q);
	assign s_waddr = clearing ? clr_q[SA_W-1:0] : addr_s1[SA_W-1:0];
	assign i_waddr = clearing ? clr_q[IA_W-1:0] : addr_s1[IA_W-1:0];
	assign wdata   = clearing ? '0 : new_word;

	// read of word w+1 never meets the write of word w, so no bypass
	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_waddr] <= wdata;
		end
		if (s_re) begin
			s_rdata_q <= smem[w_q[SA_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			imem[i_waddr] <= wdata;
		end
		if (i_re) begin
			i_rdata_q <= imem[w_q[IA_W-1:0]];
		end
	end

	// ------------------------------------------------------------ response
	logic    rsp_vld_q;
	status_t rsp_stat_q;
	logic    rsp_load;
	status_t final_stat;

	assign final_stat = (stat_q == STATUS_RANGE) ? STATUS_RANGE
		: (bad_q ? STATUS_BAD_BIT : STATUS_OK);

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = rsp_stat_q;

	// --------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		div_go    = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (range_bad || len_zero) begin
						state_d = ST_FINISH;
					end else begin
						div_go  = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!issue && !vld_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_vld_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			bad_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			vld_s1 <= issue;
			if (accept) begin
				bad_q <= 1'b0;
			end else if (vld_s1 && word_bad) begin
				bad_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// request payload and walk counters
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			map_q  <= req.map_select;
			len_q  <= req.run_length;
			stat_q <= range_bad ? STATUS_RANGE : STATUS_OK;
		end
		if (state_q == ST_DIV && div_done) begin
			w_q    <= div_quo;
			off_q  <= div_rem;
			left_q <= len_q;
		end else if (issue) begin
			w_q    <= w_q + 1'b1;
			off_q  <= '0;
			left_q <= left_q - take;
		end
		if (issue) begin
			addr_s1 <= w_q;
			mask_s1 <= mask;
		end
		if (rsp_load) begin
			rsp_stat_q <= final_stat;
		end
	end

	// ------------------------------------------------------------ assertions
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> !vld_s1)
		else $error("response built while a write-back is still in flight");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q) == ST_FINISH)
		else $error("response beat raised outside the finish state");

	a_wb_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> vld_s1 && addr_s1 == $past(w_q))
		else $error("write-back address does not follow the read");

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !issue && !vld_s1 && !req.ready)
		else $error("bitmap access during the clearing pass");

	a_word_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !map_q |-> {1'b0, addr_s1} < (START_W + 1)'(SW))
		else $error("sector word index beyond the map");

endmodule

>>> rtl/core/brf_div.sv
// ----------------------------------------------------------------------------
// brf_div
// Divide by the word size: bit position -> word, offset (reciprocal multiply).
// ----------------------------------------------------------------------------
module brf_div #(
	parameter int DIV_W     = 21,
	parameter int WORD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [DIV_W-1:0]               dividend,
	output logic                           done,
	output logic [DIV_W-1:0]               quotient,
	output logic [$clog2(WORD_BITS)-1:0]   remainder
);
	localparam int OFF_W  = $clog2(WORD_BITS);
	// m = ceil(2**(DIV_W + OFF_W) / WORD_BITS) is exact for every DIV_W-bit input
	localparam int SH     = DIV_W + OFF_W;
	localparam int M_W    = DIV_W + 2;
	localparam int PROD_W = DIV_W + M_W;
	localparam longint M_L = ((longint'(1) << SH) + longint'(WORD_BITS) - 1)
		/ longint'(WORD_BITS);
	localparam logic [M_W-1:0]   M_V = M_W'(M_L);
	localparam logic [DIV_W-1:0] D_V = DIV_W'(WORD_BITS);

	logic              p1_q;
	logic              p2_q;
	logic [DIV_W-1:0]  x_q;
	logic [DIV_W-1:0]  q_q;
	logic [PROD_W-1:0] prod;
	logic [DIV_W-1:0]  qd;

	assign prod = PROD_W'(x_q) * PROD_W'(M_V);
	assign qd   = q_q * D_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= 1'b0;
			p2_q <= 1'b0;
		end else begin
			p1_q <= go;
			p2_q <= p1_q;
		end
	end

	// first latch the operand on go, then multiply and keep the quotient
	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= dividend;
		end
		if (p1_q) begin
			q_q <= DIV_W'(prod >> SH);
		end
	end

	// remainder < WORD_BITS, so the low bits of x - q * WORD_BITS are enough
	assign done      = p2_q;
	assign quotient  = q_q;
	assign remainder = x_q[OFF_W-1:0] - qd[OFF_W-1:0];

endmodule
